### design/qrpc_pkg.sv
// Shared constants for the quadrilateral-against-rectangle clipper.
`timescale 1ns / 1ps
package qrpc_pkg;

	// Largest polygon kept by any clip pass.
	localparam int MAX_VERTICES = 8;
	// Width of a vertex count (0 to MAX_VERTICES).
	localparam int VCNT_W = 4;
	// Width of a vertex buffer address.
	localparam int VIDX_W = 3;
	// Near-parallel limit on a clipped axis: 0.002 in 16 fraction bits.
	localparam int EPS_Q = 131;
	// Coordinate bits plus interpolation fraction bits.
	localparam int T_FRAC_SUM = 61;

endpackage

### design/qrpc_front.sv
// Front end of the clipper: accepts items into a two-entry queue.
`timescale 1ns / 1ps
module qrpc_front #(
	parameter int COORD_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [7:0][COORD_BITS-1:0]            vin,
	input  logic [COORD_BITS-2:0]                 hw_in,
	input  logic [COORD_BITS-2:0]                 hh_in,
	input  logic                                  pop,
	output logic                                  head_valid,
	output logic [7:0][COORD_BITS-1:0]            head_vtx,
	output logic [COORD_BITS-2:0]                 head_hw,
	output logic [COORD_BITS-2:0]                 head_hh
);

	logic [7:0][COORD_BITS-1:0] vtx_q [2];
	logic [COORD_BITS-2:0]      hw_q [2];
	logic [COORD_BITS-2:0]      hh_q [2];
	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	logic [1:0]                 count_q;
	logic                       push;
	logic                       take;

	// The queue is full when both entries hold an item.
	assign busy       = (count_q == 2'd2);
	assign push       = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign take       = pop && head_valid;
	assign head_vtx   = vtx_q[rd_ptr_q];
	assign head_hw    = hw_q[rd_ptr_q];
	assign head_hh    = hh_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			vtx_q[wr_ptr_q] <= vin;
			hw_q[wr_ptr_q]  <= hw_in;
			hh_q[wr_ptr_q]  <= hh_in;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (take)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !take)
				count_q <= count_q + 2'd1;
			else if (take && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

### design/qrpc_cross.sv
// Crossing point unit: serial divider for t, split multiplier, offset apply.
`timescale 1ns / 1ps
module qrpc_cross #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic signed [COORD_BITS-1:0] p_a,
	input  logic signed [COORD_BITS-1:0] c_a,
	input  logic signed [COORD_BITS-1:0] p_o,
	input  logic signed [COORD_BITS-1:0] c_o,
	input  logic signed [COORD_BITS-1:0] edge_val,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] res
);

	localparam int W1     = COORD_BITS + 1;
	localparam int T_FRAC = qrpc_pkg::T_FRAC_SUM - COORD_BITS;
	localparam int TW     = T_FRAC + 1;
	localparam int LO     = W1 / 2;
	localparam int HI     = W1 - LO;
	localparam int PW     = TW + W1;
	localparam int CW     = $clog2(T_FRAC);

	localparam logic [2:0] C_IDLE  = 3'd0;
	localparam logic [2:0] C_DIV   = 3'd1;
	localparam logic [2:0] C_MUL1  = 3'd2;
	localparam logic [2:0] C_MUL2  = 3'd3;
	localparam logic [2:0] C_SUM   = 3'd4;
	localparam logic [2:0] C_APPLY = 3'd5;

	function automatic logic [W1-1:0] mag1(input logic signed [W1-1:0] v);
		mag1 = v[W1-1] ? W1'(-v) : W1'(v);
	endfunction

	logic [2:0]                  state_q;
	logic [CW-1:0]               cnt_q;
	logic [W1-1:0]               dm_q;
	logic [W1-1:0]               rem_q;
	logic [TW-1:0]               t_q;
	logic [W1-1:0]               dmo_q;
	logic                        dir_q;
	logic signed [COORD_BITS-1:0] po_q;
	logic [TW+LO-1:0]            plo_q;
	logic [TW+HI-1:0]            phi_q;
	logic [W1-1:0]               off_q;
	logic                        done_q;
	logic signed [COORD_BITS-1:0] res_q;

	logic signed [W1-1:0] den;
	logic signed [W1-1:0] num_s;
	logic signed [W1-1:0] d_o;
	logic [W1-1:0]        dm;
	logic [W1-1:0]        num0;
	logic [W1:0]          rem2;
	logic                 fits;
	logic [PW-1:0]        sum;
	logic signed [W1-1:0] po_ext;
	logic signed [W1-1:0] applied;

	// Differences on both axes, taken when a crossing is requested.
	always_comb begin
		den   = $signed({c_a[COORD_BITS-1], c_a}) - $signed({p_a[COORD_BITS-1], p_a});
		num_s = $signed({edge_val[COORD_BITS-1], edge_val})
			- $signed({p_a[COORD_BITS-1], p_a});
		d_o   = $signed({c_o[COORD_BITS-1], c_o}) - $signed({p_o[COORD_BITS-1], p_o});
		dm    = mag1(den);
		num0  = mag1(num_s);
	end

	// One quotient bit per cycle of restoring division.
	assign rem2 = {rem_q, 1'b0};
	assign fits = (rem2 >= {1'b0, dm_q});

	// Product of the two halves and the final offset.
	assign sum     = PW'(plo_q) + (PW'(phi_q) << LO);
	assign po_ext  = $signed({po_q[COORD_BITS-1], po_q});
	assign applied = dir_q ? (po_ext - $signed(off_q)) : (po_ext + $signed(off_q));

	assign done = done_q;
	assign res  = res_q;

	// Sequencer of the crossing computation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (go) begin
						cnt_q <= '0;
						if (dm < W1'(qrpc_pkg::EPS_Q) || num0 >= dm)
							state_q <= C_MUL1;
						else
							state_q <= C_DIV;
					end
				end
				C_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(T_FRAC - 1))
						state_q <= C_MUL1;
				end
				C_MUL1: begin
					state_q <= C_MUL2;
				end
				C_MUL2: begin
					state_q <= C_SUM;
				end
				C_SUM: begin
					state_q <= C_APPLY;
				end
				C_APPLY: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (go) begin
					dm_q  <= dm;
					rem_q <= num0;
					dmo_q <= mag1(d_o);
					dir_q <= d_o[W1-1];
					po_q  <= p_o;
					if (dm < W1'(qrpc_pkg::EPS_Q))
						t_q <= '0;
					else if (num0 >= dm)
						t_q <= TW'(1) << T_FRAC;
					else
						t_q <= '0;
				end
			end
			C_DIV: begin
				rem_q <= fits ? W1'(rem2 - {1'b0, dm_q}) : W1'(rem2);
				t_q   <= {t_q[TW-2:0], fits};
			end
			C_MUL1: begin
				plo_q <= t_q * dmo_q[LO-1:0];
			end
			C_MUL2: begin
				phi_q <= t_q * dmo_q[W1-1:LO];
			end
			C_SUM: begin
				off_q <= sum[T_FRAC +: W1];
			end
			C_APPLY: begin
				res_q <= applied[COORD_BITS-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule

### design/qrpc_back.sv
// Back end of the clipper: four clip passes over vertex buffers and result output.
`timescale 1ns / 1ps
module qrpc_back #(
	parameter int COORD_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  logic [7:0][COORD_BITS-1:0]      head_vtx,
	input  logic [COORD_BITS-2:0]           head_hw,
	input  logic [COORD_BITS-2:0]           head_hh,
	output logic                            pop,
	output logic                            strobe,
	output logic signed [COORD_BITS-1:0]    out_x,
	output logic signed [COORD_BITS-1:0]    out_y,
	output logic [qrpc_pkg::VCNT_W-1:0]     vertex_count,
	output logic                            empty_res,
	output logic                            last
);

	localparam int CB  = COORD_BITS;
	localparam int VW  = 2 * CB;
	localparam int NW  = qrpc_pkg::VCNT_W;
	localparam int IW  = qrpc_pkg::VIDX_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_LDP   = 4'd2;
	localparam logic [3:0] S_RDC   = 4'd3;
	localparam logic [3:0] S_LDC   = 4'd4;
	localparam logic [3:0] S_EVAL  = 4'd5;
	localparam logic [3:0] S_CROSS = 4'd6;
	localparam logic [3:0] S_PUTC  = 4'd7;
	localparam logic [3:0] S_NEXT  = 4'd8;
	localparam logic [3:0] S_PEND  = 4'd9;
	localparam logic [3:0] S_ORD   = 4'd10;
	localparam logic [3:0] S_OUTV  = 4'd11;

	logic [3:0]    state_q;
	logic [1:0]    pass_q;
	logic [IW-1:0] idx_q;
	logic [NW-1:0] n_src_q;
	logic [NW-1:0] n_dst_q;
	logic          put_cur_q;
	logic [VW-1:0] prev_q;
	logic [VW-1:0] cur_q;
	logic [VW-1:0] in_vtx_q [4];
	logic [CB-2:0] hw_q;
	logic [CB-2:0] hh_q;

	logic [VW-1:0] mem_a [qrpc_pkg::MAX_VERTICES];
	logic [VW-1:0] mem_b [qrpc_pkg::MAX_VERTICES];
	logic [VW-1:0] rd_a_q;
	logic [VW-1:0] rd_b_q;
	logic [VW-1:0] rd_in_q;

	logic                 strobe_q;
	logic signed [CB-1:0] out_x_q;
	logic signed [CB-1:0] out_y_q;
	logic [NW-1:0]        count_q;
	logic                 empty_q;
	logic                 last_q;

	logic [IW-1:0]        rd_addr;
	logic [VW-1:0]        rdata;
	logic                 axis_x;
	logic                 above;
	logic signed [CB-1:0] ext_w;
	logic signed [CB-1:0] ext_h;
	logic signed [CB-1:0] edge_val;
	logic signed [CB-1:0] ca;
	logic signed [CB-1:0] pa;
	logic signed [CB-1:0] co;
	logic signed [CB-1:0] po;
	logic                 c_in;
	logic                 p_in;
	logic                 p_out;
	logic                 need_cross;
	logic                 room;
	logic                 wr_en;
	logic [VW-1:0]        wr_data;
	logic                 x_go;
	logic                 x_done;
	logic signed [CB-1:0] x_res;

	// Pass order: bottom, left, top, right.
	assign axis_x = pass_q[0];
	assign above  = !pass_q[1];
	assign ext_w  = $signed({1'b0, hw_q});
	assign ext_h  = $signed({1'b0, hh_q});

	always_comb begin
		unique case (pass_q)
			2'd0: edge_val = -ext_h;
			2'd1: edge_val = -ext_w;
			2'd2: edge_val = ext_h;
			default: edge_val = ext_w;
		endcase
	end

	// Coordinates on the clipped axis and on the other axis.
	always_comb begin
		ca = axis_x ? $signed(cur_q[VW-1:CB])  : $signed(cur_q[CB-1:0]);
		pa = axis_x ? $signed(prev_q[VW-1:CB]) : $signed(prev_q[CB-1:0]);
		co = axis_x ? $signed(cur_q[CB-1:0])   : $signed(cur_q[VW-1:CB]);
		po = axis_x ? $signed(prev_q[CB-1:0])  : $signed(prev_q[VW-1:CB]);
		c_in  = above ? (ca > edge_val) : (ca < edge_val);
		p_in  = above ? (pa > edge_val) : (pa < edge_val);
		p_out = above ? (pa < edge_val) : (pa > edge_val);
		need_cross = (c_in && p_out) || (!c_in && p_in);
	end

	// Buffer read address and source selection.
	assign rd_addr = (state_q == S_START) ? IW'(n_src_q - NW'(1)) : idx_q;

	always_comb begin
		if (state_q == S_ORD || state_q == S_OUTV)
			rdata = rd_a_q;
		else if (pass_q == 2'd0)
			rdata = rd_in_q;
		else if (pass_q[0])
			rdata = rd_b_q;
		else
			rdata = rd_a_q;
	end

	// Buffer writes: kept vertices and crossing points, dropped once full.
	assign room  = (n_dst_q < NW'(qrpc_pkg::MAX_VERTICES));
	assign x_go  = (state_q == S_EVAL) && need_cross;

	always_comb begin
		wr_data = cur_q;
		if (state_q == S_CROSS)
			wr_data = axis_x ? {edge_val, x_res} : {x_res, edge_val};
	end

	assign wr_en = room && (((state_q == S_EVAL) && c_in && !p_out)
		|| ((state_q == S_CROSS) && x_done) || (state_q == S_PUTC));

	// Vertex buffers, written at one address and read at one.
	always_ff @(posedge clk) begin
		if (wr_en && pass_q[0])
			mem_a[n_dst_q[IW-1:0]] <= wr_data;
		if (wr_en && !pass_q[0])
			mem_b[n_dst_q[IW-1:0]] <= wr_data;
		rd_a_q  <= mem_a[rd_addr];
		rd_b_q  <= mem_b[rd_addr];
		rd_in_q <= in_vtx_q[rd_addr[1:0]];
	end

	// Item taken from the queue.
	assign pop = (state_q == S_IDLE) && head_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int k = 0; k < 4; k++)
				in_vtx_q[k] <= {head_vtx[2 * k], head_vtx[2 * k + 1]};
			hw_q <= head_hw;
			hh_q <= head_hh;
		end
		if (state_q == S_LDP)
			prev_q <= rdata;
		else if (state_q == S_NEXT)
			prev_q <= cur_q;
		if (state_q == S_LDC)
			cur_q <= rdata;
		if (state_q == S_OUTV) begin
			out_x_q <= $signed(rd_a_q[VW-1:CB]);
			out_y_q <= $signed(rd_a_q[CB-1:0]);
		end else if (state_q == S_PEND) begin
			out_x_q <= '0;
			out_y_q <= '0;
		end
	end

	// Pass sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pass_q    <= 2'd0;
			idx_q     <= '0;
			n_src_q   <= '0;
			n_dst_q   <= '0;
			put_cur_q <= 1'b0;
			strobe_q  <= 1'b0;
			count_q   <= '0;
			empty_q   <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (wr_en)
				n_dst_q <= n_dst_q + NW'(1);
			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						pass_q  <= 2'd0;
						n_src_q <= NW'(4);
						n_dst_q <= '0;
						state_q <= S_START;
					end
				end
				S_START: begin
					idx_q   <= '0;
					state_q <= (n_src_q == '0) ? S_PEND : S_LDP;
				end
				S_LDP: begin
					state_q <= S_RDC;
				end
				S_RDC: begin
					state_q <= S_LDC;
				end
				S_LDC: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					put_cur_q <= c_in;
					state_q   <= need_cross ? S_CROSS : S_NEXT;
				end
				S_CROSS: begin
					if (x_done)
						state_q <= put_cur_q ? S_PUTC : S_NEXT;
				end
				S_PUTC: begin
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (NW'(idx_q) == n_src_q - NW'(1)) begin
						state_q <= S_PEND;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_RDC;
					end
				end
				S_PEND: begin
					n_src_q <= n_dst_q;
					n_dst_q <= '0;
					idx_q   <= '0;
					if (pass_q == 2'd3) begin
						if (n_dst_q == '0) begin
							strobe_q <= 1'b1;
							count_q  <= '0;
							empty_q  <= 1'b1;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_ORD;
						end
					end else begin
						pass_q  <= pass_q + 2'd1;
						state_q <= S_START;
					end
				end
				S_ORD: begin
					state_q <= S_OUTV;
				end
				S_OUTV: begin
					strobe_q <= 1'b1;
					count_q  <= n_src_q;
					empty_q  <= 1'b0;
					if (NW'(idx_q) == n_src_q - NW'(1)) begin
						last_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						last_q  <= 1'b0;
						idx_q   <= idx_q + IW'(1);
						state_q <= S_ORD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Shared crossing point unit.
	qrpc_cross #(
		.COORD_BITS(COORD_BITS)
	) u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (x_go),
		.p_a      (pa),
		.c_a      (ca),
		.p_o      (po),
		.c_o      (co),
		.edge_val (edge_val),
		.done     (x_done),
		.res      (x_res)
	);

	assign strobe       = strobe_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign vertex_count = count_q;
	assign empty_res    = empty_q;
	assign last         = last_q;

endmodule

### design/quad_rect_polygon_clipper.sv
// Top level of the quadrilateral-against-rectangle clipper.
`timescale 1ns / 1ps
// Clips a quadrilateral against a rectangle centred on the origin, one edge at a
// time (bottom, left, top, right), and returns the surviving vertices one per
// strobe, with last on the final one; a fully clipped item gives a single
// strobe with empty_res set. The receiver cannot stall: each result is on the
// ports for exactly one cycle. Items queue two deep at the input; busy is high
// while both entries are taken. Each of the four passes visits every vertex of
// the polygon, with an extra write where a kept vertex follows a crossing, and
// every edge crossing runs through the shared crossing unit, whose serial
// divider produces one quotient bit per cycle (61 - COORD_BITS bits); the
// divider is skipped where the edge is near-parallel or t reaches one.
module quad_rect_polygon_clipper #(
	parameter int COORD_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_BITS-1:0]    v0_x,
	input  logic signed [COORD_BITS-1:0]    v0_y,
	input  logic signed [COORD_BITS-1:0]    v1_x,
	input  logic signed [COORD_BITS-1:0]    v1_y,
	input  logic signed [COORD_BITS-1:0]    v2_x,
	input  logic signed [COORD_BITS-1:0]    v2_y,
	input  logic signed [COORD_BITS-1:0]    v3_x,
	input  logic signed [COORD_BITS-1:0]    v3_y,
	input  logic [COORD_BITS-2:0]           half_width,
	input  logic [COORD_BITS-2:0]           half_height,
	output logic                            strobe,
	output logic signed [COORD_BITS-1:0]    out_x,
	output logic signed [COORD_BITS-1:0]    out_y,
	output logic [qrpc_pkg::VCNT_W-1:0]     vertex_count,
	output logic                            empty_res,
	output logic                            last
);

	logic [7:0][COORD_BITS-1:0] vin;
	logic [7:0][COORD_BITS-1:0] head_vtx;
	logic [COORD_BITS-2:0]      head_hw;
	logic [COORD_BITS-2:0]      head_hh;
	logic                       head_valid;
	logic                       pop;

	// Vertices in polygon order, x before y.
	assign vin = {v3_y, v3_x, v2_y, v2_x, v1_y, v1_x, v0_y, v0_x};

	qrpc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.vin        (vin),
		.hw_in      (half_width),
		.hh_in      (half_height),
		.pop        (pop),
		.head_valid (head_valid),
		.head_vtx   (head_vtx),
		.head_hw    (head_hw),
		.head_hh    (head_hh)
	);

	qrpc_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_vtx     (head_vtx),
		.head_hw      (head_hw),
		.head_hh      (head_hh),
		.pop          (pop),
		.strobe       (strobe),
		.out_x        (out_x),
		.out_y        (out_y),
		.vertex_count (vertex_count),
		.empty_res    (empty_res),
		.last         (last)
	);

endmodule

### design/qrpc_checker.sv
// Port-level checks on the clipper's result stream, bound to the top level.
`timescale 1ns / 1ps
module qrpc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        strobe,
	input logic [qrpc_pkg::VCNT_W-1:0] vertex_count,
	input logic                        empty_res,
	input logic                        last
);

	// An empty item is a single, final result with no vertices.
	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && empty_res |-> last && vertex_count == '0)
		else $error("empty result not final or count nonzero");

	// A vertex result carries a count between one and the buffer size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !empty_res |-> vertex_count != '0
			&& vertex_count <= qrpc_pkg::VCNT_W'(qrpc_pkg::MAX_VERTICES))
		else $error("vertex count out of range");

	// Within one polygon the next vertex follows after a gap without strobe and carries the same count.
	a_count_held: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> !strobe ##1 strobe && !empty_res
			&& vertex_count == $past(vertex_count, 2))
		else $error("polygon results broken or count changed");

	// The final result of an item is never followed at once by another.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result directly after final result");

endmodule

bind quad_rect_polygon_clipper qrpc_checker u_qrpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.strobe       (strobe),
	.vertex_count (vertex_count),
	.empty_res    (empty_res),
	.last         (last)
);
